@@ rtl/core/ospi_pkg.sv @@
// Shared types and constants for the object stream index parser.
// Holds the item structs, parse phases, result kinds and register indexes.
// Depends on nothing.
package ospi_pkg;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [31:0] class_hash;
    logic [47:0]        payload_offset;
    logic [47:0]        payload_size;
    logic               last_object;
  } out_item_t;

  typedef struct packed {
    logic [7:0] expected_major;
    logic [7:0] expected_minor;
    logic [7:0] expected_patch;
  } version_cfg_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SIZE,
    PH_HASH,
    PH_PAYLOAD,
    PH_DONE,
    PH_ERROR
  } phase_t;

  localparam logic [1:0] KIND_OBJECT      = 2'd0;
  localparam logic [1:0] KIND_BAD_MARK    = 2'd1;
  localparam logic [1:0] KIND_BAD_VERSION = 2'd2;
  localparam logic [1:0] KIND_EMPTY       = 2'd3;

  localparam logic [1:0] REG_MAJOR = 2'd0;
  localparam logic [1:0] REG_MINOR = 2'd1;
  localparam logic [1:0] REG_PATCH = 2'd2;

  localparam logic [7:0] MARK_FIRST  = 8'h73;
  localparam logic [7:0] MARK_SECOND = 8'h72;

  localparam int POS_MARK_FIRST  = 0;
  localparam int POS_MARK_SECOND = 1;
  localparam int POS_MAJOR       = 3;
  localparam int POS_MINOR       = 4;
  localparam int POS_PATCH       = 5;
  localparam int COUNT_POS       = 14;
  localparam int BODY_POS        = 18;

  localparam logic [2:0] SIZE_LAST_BYTE = 3'd7;
  localparam logic [2:0] HASH_LAST_BYTE = 3'd3;

endpackage

@@ rtl/core/ospi_fsm.sv @@
// Parse state and per-byte step logic of the object stream index parser.
// Holds the phase, offset, counters and field accumulator and forms one result.
// Depends on ospi_pkg.
module ospi_fsm #(
  parameter int OFFSET_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  ospi_pkg::in_item_t   item,
  input  ospi_pkg::version_cfg_t cfg,
  output logic                 res_valid,
  output ospi_pkg::out_item_t  res
);
  import ospi_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
  localparam logic [63:0]            SIZE_LIMIT = 64'(OFFSET_MAX);

  phase_t                 phase, phase_next;
  logic [2:0]             idx, idx_next;
  logic [OFFSET_BITS-1:0] offset, offset_next;
  logic [31:0]            objects_left, objects_next;
  logic [63:0]            acc, acc_next;
  logic [OFFSET_BITS-1:0] payload_left, left_next;

  logic                   active;
  phase_t                 cur_phase;
  logic [OFFSET_BITS-1:0] off_inc, cur_off, poff, size_sat, left_dec;
  logic [7:0]             b;
  logic                   mark_bad, ver_bad, in_count, count_end;
  logic [31:0]            word32, objects_dec;
  logic [63:0]            size_full, poff_wide, size_wide;

  always_comb begin
    b         = item.stream_byte;
    active    = item.first_byte || phase == PH_HEADER || phase == PH_SIZE ||
                phase == PH_HASH || phase == PH_PAYLOAD;
    cur_phase = item.first_byte ? PH_HEADER : phase;
    off_inc   = (offset == OFFSET_MAX) ? offset : offset + OFFSET_BITS'(1);
    cur_off   = item.first_byte ? '0 : off_inc;
    poff      = (cur_off == OFFSET_MAX) ? cur_off : cur_off + OFFSET_BITS'(1);
    mark_bad  = (cur_off == OFFSET_BITS'(POS_MARK_FIRST) && b != MARK_FIRST) ||
                (cur_off == OFFSET_BITS'(POS_MARK_SECOND) && b != MARK_SECOND);
    ver_bad   = (cur_off == OFFSET_BITS'(POS_MAJOR) && b != cfg.expected_major) ||
                (cur_off == OFFSET_BITS'(POS_MINOR) && b != cfg.expected_minor) ||
                (cur_off == OFFSET_BITS'(POS_PATCH) && b != cfg.expected_patch);
    in_count  = cur_off >= OFFSET_BITS'(COUNT_POS) && cur_off < OFFSET_BITS'(BODY_POS);
    count_end = cur_off == OFFSET_BITS'(BODY_POS - 1);
    word32    = {b, acc[63:40]};
    size_full = {b, acc[63:8]};
    size_sat  = (size_full > SIZE_LIMIT) ? OFFSET_MAX : size_full[OFFSET_BITS-1:0];
    objects_dec = (objects_left != 32'd0) ? objects_left - 32'd1 : objects_left;
    left_dec  = (payload_left != '0) ? payload_left - OFFSET_BITS'(1) : payload_left;
    poff_wide = 64'(poff);
    size_wide = 64'(payload_left);
  end

  // Next state.
  always_comb begin
    phase_next   = phase;
    idx_next     = idx;
    offset_next  = offset;
    objects_next = objects_left;
    acc_next     = acc;
    left_next    = payload_left;
    if (fire && active) begin
      offset_next = cur_off;
      unique case (cur_phase)
        PH_HEADER: begin
          phase_next = PH_HEADER;
          idx_next   = '0;
          if (mark_bad || ver_bad) begin
            phase_next = PH_ERROR;
          end else if (in_count) begin
            acc_next = {b, acc[63:8]};
            if (count_end) begin
              objects_next = word32;
              phase_next   = (word32 == 32'd0) ? PH_DONE : PH_SIZE;
            end
          end
        end
        PH_SIZE: begin
          acc_next = {b, acc[63:8]};
          idx_next = idx + 3'd1;
          if (idx == SIZE_LAST_BYTE) begin
            left_next  = size_sat;
            idx_next   = '0;
            phase_next = PH_HASH;
          end
        end
        PH_HASH: begin
          acc_next = {b, acc[63:8]};
          idx_next = idx + 3'd1;
          if (idx == HASH_LAST_BYTE) begin
            objects_next = objects_dec;
            idx_next     = '0;
            if (payload_left != '0) begin
              phase_next = PH_PAYLOAD;
            end else begin
              phase_next = (objects_dec == 32'd0) ? PH_DONE : PH_SIZE;
            end
          end
        end
        PH_PAYLOAD: begin
          left_next = left_dec;
          if (left_dec == '0) begin
            idx_next   = '0;
            phase_next = (objects_left == 32'd0) ? PH_DONE : PH_SIZE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result.
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (fire && active) begin
      unique case (cur_phase)
        PH_HEADER: begin
          if (mark_bad) begin
            res_valid       = 1'b1;
            res.result_kind = KIND_BAD_MARK;
          end else if (ver_bad) begin
            res_valid       = 1'b1;
            res.result_kind = KIND_BAD_VERSION;
          end else if (count_end && word32 == 32'd0) begin
            res_valid       = 1'b1;
            res.result_kind = KIND_EMPTY;
          end
        end
        PH_HASH: begin
          if (idx == HASH_LAST_BYTE) begin
            res_valid          = 1'b1;
            res.result_kind    = KIND_OBJECT;
            res.class_hash     = word32;
            res.payload_offset = poff_wide[47:0];
            res.payload_size   = size_wide[47:0];
            res.last_object    = objects_left == 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      idx    <= '0;
      offset <= '0;
    end else begin
      phase  <= phase_next;
      idx    <= idx_next;
      offset <= offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      objects_left <= '0;
      acc          <= '0;
      payload_left <= '0;
    end else begin
      objects_left <= objects_next;
      acc          <= acc_next;
      payload_left <= left_next;
    end
  end

endmodule

@@ rtl/core/object_stream_index_parser_core.sv @@
// Top level of the object stream index parser; depends on ospi_pkg and ospi_fsm.
// Order: an accepted item waits in the input register and is parsed from there when it fires,
// and its result, if any, is then offered from the result register.
// Throughput: one item per cycle; a held result stalls the input register and input.
// Reset: synchronous rst empties both registers, returns the parse to idle
// and clears the three version registers to zero.
module object_stream_index_parser_core #(
  parameter int OFFSET_BITS = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  ospi_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output ospi_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import ospi_pkg::*;

  version_cfg_t cfg;
  logic         s1_valid;
  in_item_t     s1_item;
  logic         advance;
  logic         fire;
  logic         res_valid;
  out_item_t    res;

  assign advance    = !result_valid || result_ready;
  assign fire       = s1_valid && advance;
  assign item_ready = !s1_valid || advance;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAJOR: cfg.expected_major <= cfg_data;
        REG_MINOR: cfg.expected_minor <= cfg_data;
        REG_PATCH: cfg.expected_patch <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  ospi_fsm #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_fsm (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (s1_item),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

  a_result_from_stage : assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid))
    else $error("result appeared without a registered item");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input not ready while result register is empty");

  a_error_fields_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind != KIND_OBJECT |->
      result.class_hash == 32'sd0 && result.payload_size == 48'd0 &&
      result.payload_offset == 48'd0 && !result.last_object)
    else $error("non-object result carries object fields");

  a_stage_holds : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("registered item lost during stall");

endmodule
